FILE: rtl/calendar_date_counter_defines.svh
// Assertion macros shared by the calendar date counter RTL.
`ifndef CALENDAR_DATE_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CAL_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CAL_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/cal_pkg.sv
// Types, constants and calendar functions for the calendar date counter.
package cal_pkg;

  // Field widths
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 12;
  localparam int ADV_W   = 16;

  // Number of advance count bits actually used
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = (COUNT_BITS < ADV_W) ? COUNT_BITS : ADV_W;

  // Calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC  = 5'd31;
  localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;
  localparam logic [YEAR_W-1:0]  YEAR_RESET    = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_SET_MIN  = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_SET_MAX  = 12'd2100;
  localparam logic [YEAR_W-1:0]  YEAR_MAX      = 12'd4095;

  // Reciprocal of 25 scaled by 2^15, exact for 12-bit years
  localparam logic [10:0] DIV25_RECIP = 11'd1311;

  // Days per month, leap day handled separately; unused codes read as zero
  localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  typedef enum logic {
    KIND_SET,
    KIND_ADVANCE
  } cal_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_MONTH,
    ST_BAD_YEAR,
    ST_BAD_DAY
  } cal_status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take the input transaction
    logic leap_en;   // latch the leap flag of the working year
    logic check_en;  // run the set checks and load on success
    logic step_en;   // one advance step
    logic out_load;  // move the result into the output register
  } cal_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cal_kind_e kind;
    logic      step_done;
    logic      year_wrap;
  } cal_sts_t;

  // Divisible by 25: estimate the quotient, multiply back with shifts
  function automatic logic is_div25(input logic [YEAR_W-1:0] y);
    logic [22:0]       prod;
    logic [7:0]        quo;
    logic [YEAR_W-1:0] back;
    prod = 23'(y) * 23'(DIV25_RECIP);
    quo  = prod[22:15];
    back = (12'(quo) << 4) + (12'(quo) << 3) + 12'(quo);
    return back == y;
  endfunction

  // Gregorian leap year: by 4, and not by 100 unless by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic d25;
    d25 = is_div25(y);
    return (y[1:0] == 2'd0) && (!d25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = MONTH_DAYS[m];
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_DAYS;
    end
    return len;
  endfunction

endpackage

FILE: rtl/cal_ctrl.sv
// Sequencing state machine for the calendar date counter.
module cal_ctrl import cal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cal_cmd_t cmd_o,
  input  cal_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAP,
    S_CHECK,
    S_STEP,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Result register fills on finish and empties when taken
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_LEAP;
          end
        end
        S_LEAP: begin
          state_q <= (sts_i.kind == KIND_SET) ? S_CHECK : S_STEP;
        end
        S_CHECK: begin
          state_q <= S_FINISH;
        end
        S_STEP: begin
          if (sts_i.step_done) begin
            state_q <= S_FINISH;
          end else if (sts_i.year_wrap) begin
            state_q <= S_LEAP;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from state
  assign cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.leap_en  = (state_q == S_LEAP);
  assign cmd_o.check_en = (state_q == S_CHECK);
  assign cmd_o.step_en  = (state_q == S_STEP);
  assign cmd_o.out_load = (state_q == S_FINISH) && out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/cal_dpath.sv
// Date registers, set checks and month-at-a-time advance stepping.
module cal_dpath import cal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cal_cmd_t           cmd_i,
  output cal_sts_t           sts_o,
  input  logic               kind_i,
  input  logic [MONTH_W-1:0] new_month_i,
  input  logic [DAY_W-1:0]   new_day_i,
  input  logic [YEAR_W-1:0]  new_year_i,
  input  logic [ADV_W-1:0]   advance_count_i,
  output logic [MONTH_W-1:0] cur_month_o,
  output logic [DAY_W-1:0]   cur_day_o,
  output logic [YEAR_W-1:0]  cur_year_o,
  output logic [MONTH_W-1:0] old_month_o,
  output logic [DAY_W-1:0]   old_day_o,
  output logic [YEAR_W-1:0]  old_year_o,
  output logic [1:0]         status_o
);

  // Stored date
  logic [MONTH_W-1:0] month_q, month_d;
  logic [DAY_W-1:0]   day_q, day_d;
  logic [YEAR_W-1:0]  year_q, year_d;

  // Captured transaction
  cal_kind_e          kind_q;
  logic [MONTH_W-1:0] nm_q;
  logic [DAY_W-1:0]   nd_q;
  logic [YEAR_W-1:0]  ny_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MONTH_W-1:0] old_month_q;
  logic [DAY_W-1:0]   old_day_q;
  logic [YEAR_W-1:0]  old_year_q;
  logic               leap_q;
  cal_status_e        status_q, status_d;

  // Output register
  logic [MONTH_W-1:0] out_cur_month_q, out_old_month_q;
  logic [DAY_W-1:0]   out_cur_day_q, out_old_day_q;
  logic [YEAR_W-1:0]  out_cur_year_q, out_old_year_q;
  cal_status_e        out_status_q;

  // Leap flag of the year in question
  logic [YEAR_W-1:0] leap_year;
  assign leap_year = (kind_q == KIND_SET) ? ny_q : year_q;

  // Set checks, month first, then year, then day
  logic [DAY_W-1:0] set_len;
  assign set_len = month_len(nm_q, leap_q);

  always_comb begin
    priority if (nm_q == '0 || nm_q > MONTH_DEC) begin
      status_d = ST_BAD_MONTH;
    end else if (ny_q < YEAR_SET_MIN || ny_q > YEAR_SET_MAX) begin
      status_d = ST_BAD_YEAR;
    end else if (nd_q == '0 || nd_q > set_len) begin
      status_d = ST_BAD_DAY;
    end else begin
      status_d = ST_OK;
    end
  end

  // Advance step: finish inside the month, jump to the next month's first or saturate
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   room;
  logic [CNT_W+4:0]   cnt_ext;
  logic [CNT_W+4:0]   room_ext;
  logic [CNT_W+4:0]   cnt_left;
  logic               fits;
  logic               at_end;

  assign cur_len  = month_len(month_q, leap_q);
  assign room     = (day_q < cur_len) ? cur_len - day_q : '0;
  assign cnt_ext  = {5'd0, cnt_q};
  assign room_ext = (CNT_W + 5)'(room) + (CNT_W + 5)'(1);
  assign cnt_left = cnt_ext - room_ext;
  assign fits     = (cnt_ext <= (CNT_W + 5)'(room));
  assign at_end   = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);

  assign sts_o.kind      = kind_q;
  assign sts_o.step_done = fits || at_end;
  assign sts_o.year_wrap = !fits && (month_q == MONTH_DEC) && (year_q != YEAR_MAX);

  // Next date
  always_comb begin
    month_d = month_q;
    day_d   = day_q;
    year_d  = year_q;
    cnt_d   = cnt_q;
    if (cmd_i.check_en && status_d == ST_OK) begin
      month_d = nm_q;
      day_d   = nd_q;
      year_d  = ny_q;
    end else if (cmd_i.step_en) begin
      if (fits) begin
        day_d = day_q + cnt_ext[DAY_W-1:0];
        cnt_d = '0;
      end else if (month_q != MONTH_DEC) begin
        month_d = month_q + MONTH_W'(1);
        day_d   = DAY_FIRST;
        cnt_d   = cnt_left[CNT_W-1:0];
      end else if (year_q != YEAR_MAX) begin
        year_d  = year_q + YEAR_W'(1);
        month_d = MONTH_JAN;
        day_d   = DAY_FIRST;
        cnt_d   = cnt_left[CNT_W-1:0];
      end else begin
        // saturate at the last day of the last year
        day_d = DAY_LAST_DEC;
        cnt_d = '0;
      end
    end
  end

  // Stored date, reset to 1 January 1900
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= MONTH_JAN;
      day_q   <= DAY_FIRST;
      year_q  <= YEAR_RESET;
    end else begin
      month_q <= month_d;
      day_q   <= day_d;
      year_q  <= year_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q      <= cal_kind_e'(kind_i);
      nm_q        <= new_month_i;
      nd_q        <= new_day_i;
      ny_q        <= new_year_i;
      cnt_q       <= advance_count_i[CNT_W-1:0];
      old_month_q <= month_q;
      old_day_q   <= day_q;
      old_year_q  <= year_q;
      status_q    <= ST_OK;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.check_en) begin
        status_q <= status_d;
      end
    end
    if (cmd_i.leap_en) begin
      leap_q <= is_leap(leap_year);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cur_month_q <= month_q;
      out_cur_day_q   <= day_q;
      out_cur_year_q  <= year_q;
      out_old_month_q <= old_month_q;
      out_old_day_q   <= old_day_q;
      out_old_year_q  <= old_year_q;
      out_status_q    <= status_q;
    end
  end

  assign cur_month_o = out_cur_month_q;
  assign cur_day_o   = out_cur_day_q;
  assign cur_year_o  = out_cur_year_q;
  assign old_month_o = out_old_month_q;
  assign old_day_o   = out_old_day_q;
  assign old_year_o  = out_old_year_q;
  assign status_o    = out_status_q;

endmodule

FILE: rtl/calendar_date_counter.sv
// Top level of the calendar date counter: controller, datapath and checks.
// Keeps a Gregorian date, reset to 1 January 1900. One input transaction is
// either a set (new_month/new_day/new_year, checked month, year, day in that
// order) or an advance by advance_count days; each gives one result with the
// date before and after it and a status code (ok for every advance).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. in_stall_o is high while a transaction is being worked on.
// From input acceptance to out_valid_o, a set passes the leap, check and finish
// states; an advance passes the leap and step states, stepping a month at a
// time and returning to the leap state at each year boundary, then finish.
// The controller goes back to idle as the result is registered and only then
// accepts the next input transaction, so transactions do not overlap.
// The result sits in an output register: a stalled receiver holds it there
// while the next input transaction is already being accepted and worked on;
// that one then waits until the register is freed.
// The date saturates at 31 December 4095.
// Reset is asynchronous, active low, and clears the date and control state.
`include "calendar_date_counter_defines.svh"

module calendar_date_counter import cal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [MONTH_W-1:0] new_month_i,
  input  logic [DAY_W-1:0]   new_day_i,
  input  logic [YEAR_W-1:0]  new_year_i,
  input  logic [ADV_W-1:0]   advance_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MONTH_W-1:0] cur_month_o,
  output logic [DAY_W-1:0]   cur_day_o,
  output logic [YEAR_W-1:0]  cur_year_o,
  output logic [MONTH_W-1:0] old_month_o,
  output logic [DAY_W-1:0]   old_day_o,
  output logic [YEAR_W-1:0]  old_year_o,
  output logic [1:0]         status_o
);

  cal_cmd_t cmd;
  cal_sts_t sts;

  cal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cal_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .new_month_i     (new_month_i),
    .new_day_i       (new_day_i),
    .new_year_i      (new_year_i),
    .advance_count_i (advance_count_i),
    .cur_month_o     (cur_month_o),
    .cur_day_o       (cur_day_o),
    .cur_year_o      (cur_year_o),
    .old_month_o     (old_month_o),
    .old_day_o       (old_day_o),
    .old_year_o      (old_year_o),
    .status_o        (status_o)
  );

  // Checks
  logic in_acc;
  logic failed_set;
  logic same_date;
  logic month_ok;
  logic year_fwd;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign failed_set = out_valid_o && (status_o != ST_OK);
  assign same_date  = (cur_month_o == old_month_o) && (cur_day_o == old_day_o) &&
                      (cur_year_o == old_year_o);
  assign month_ok   = (cur_month_o != '0) && (cur_month_o <= MONTH_DEC) && (cur_day_o != '0);
  assign year_fwd   = (cur_year_o >= old_year_o);

  `CAL_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o, "not busy after accept")
  `CAL_ASSERT_IMP(a_failed_set_keeps, clk_i, rst_ni, failed_set, same_date, "failed set moved date")
  `CAL_ASSERT_IMP(a_date_in_range, clk_i, rst_ni, out_valid_o, month_ok, "result date out of range")
  `CAL_ASSERT_IMP(a_year_forward, clk_i, rst_ni, failed_set, year_fwd, "year moved back")

endmodule

FILE: tb/calendar_date_counter_tb.sv
// Self-checking testbench for the calendar date counter: directed and random date traffic.
`timescale 1ns / 100ps

module calendar_date_counter_tb import cal_pkg::*; ();

  // Cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 10000;
  // Length of the long receiver hold-off, in cycles
  localparam int LONG_HOLD = 60;
  // Cycles allowed after the last result for the block to settle
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] old_month;
    logic [DAY_W-1:0]   old_day;
    logic [YEAR_W-1:0]  old_year;
    cal_status_e        status;
  } date_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               kind_i          = 1'b0;
  logic [MONTH_W-1:0] new_month_i     = '0;
  logic [DAY_W-1:0]   new_day_i       = '0;
  logic [YEAR_W-1:0]  new_year_i      = '0;
  logic [ADV_W-1:0]   advance_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [MONTH_W-1:0] cur_month_o;
  logic [DAY_W-1:0]   cur_day_o;
  logic [YEAR_W-1:0]  cur_year_o;
  logic [MONTH_W-1:0] old_month_o;
  logic [DAY_W-1:0]   old_day_o;
  logic [YEAR_W-1:0]  old_year_o;
  logic [1:0]         status_o;

  // Predicted date held by the block
  logic [DAY_W-1:0]   date_day;
  logic [MONTH_W-1:0] date_month;
  logic [YEAR_W-1:0]  date_year;

  date_result_t pending_dates[$];
  int           mismatch_count    = 0;
  int           quiet_cycles      = 0;
  bit           idle_en           = 1'b1;
  bit           receiver_hold_req = 1'b0;

  calendar_date_counter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .new_month_i     (new_month_i),
    .new_day_i       (new_day_i),
    .new_year_i      (new_year_i),
    .advance_count_i (advance_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cur_month_o     (cur_month_o),
    .cur_day_o       (cur_day_o),
    .cur_year_o      (cur_year_o),
    .old_month_o     (old_month_o),
    .old_day_o       (old_day_o),
    .old_year_o      (old_year_o),
    .status_o        (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Calendar arithmetic
  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      1, 3, 5, 7, 8, 10, 12: begin
        return 31;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // Works out the result of one transaction and moves the predicted date on
  function automatic date_result_t predict_date_result(
    input cal_kind_e          kind,
    input logic [MONTH_W-1:0] m,
    input logic [DAY_W-1:0]   d,
    input logic [YEAR_W-1:0]  y,
    input logic [ADV_W-1:0]   cnt
  );
    date_result_t res;
    int unsigned  left, len, room, dy, mo, yr;
    res.old_month = date_month;
    res.old_day   = date_day;
    res.old_year  = date_year;
    res.status    = ST_OK;
    if (kind == KIND_SET) begin
      if (m < MONTH_JAN || m > MONTH_DEC) begin
        res.status = ST_BAD_MONTH;
      end else if (y < YEAR_SET_MIN || y > YEAR_SET_MAX) begin
        res.status = ST_BAD_YEAR;
      end else if (d < DAY_FIRST || d > days_in_month(m, y)) begin
        res.status = ST_BAD_DAY;
      end else begin
        date_month = m;
        date_day   = d;
        date_year  = y;
      end
    end else begin
      left = cnt & ((32'd1 << CNT_W) - 1);
      dy   = date_day;
      mo   = date_month;
      yr   = date_year;
      // Step a month at a time; stop for good at the last day of the last year
      while (left > 0) begin
        len  = days_in_month(mo, yr);
        room = (dy < len) ? len - dy : 0;
        if (left <= room) begin
          dy   = dy + left;
          left = 0;
        end else begin
          left = left - room - 1;
          if (mo < MONTH_DEC) begin
            mo = mo + 1;
            dy = DAY_FIRST;
          end else if (yr < YEAR_MAX) begin
            yr = yr + 1;
            mo = MONTH_JAN;
            dy = DAY_FIRST;
          end else begin
            dy   = DAY_LAST_DEC;
            left = 0;
          end
        end
      end
      date_day   = DAY_W'(dy);
      date_month = MONTH_W'(mo);
      date_year  = YEAR_W'(yr);
    end
    res.cur_month = date_month;
    res.cur_day   = date_day;
    res.cur_year  = date_year;
    return res;
  endfunction

  // Offers one transaction, after a random gap when idle_en is set, and records its expected result
  task automatic send_item(
    input cal_kind_e          kind,
    input logic [MONTH_W-1:0] m,
    input logic [DAY_W-1:0]   d,
    input logic [YEAR_W-1:0]  y,
    input logic [ADV_W-1:0]   cnt
  );
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    new_month_i     <= m;
    new_day_i       <= d;
    new_year_i      <= y;
    advance_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(predict_date_result(kind, m, d, y, cnt));
  endtask

  task automatic set_date(input int unsigned m, input int unsigned d, input int unsigned y);
    send_item(KIND_SET, MONTH_W'(m), DAY_W'(d), YEAR_W'(y), ADV_W'($urandom));
  endtask

  // Set fields carry noise, which the block must ignore
  task automatic advance_by(input int unsigned cnt);
    send_item(KIND_ADVANCE, MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom),
              ADV_W'(cnt));
  endtask

  // Sender pauses until every outstanding result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // Check order, leap rules and the reset date
  task automatic test_set_validation();
    advance_by(0);
    set_date(0, 1, 2000);
    set_date(13, 15, 4095);
    set_date(15, 0, 0);
    set_date(6, 31, 1899);
    set_date(1, 1, 2101);
    set_date(4, 31, 2020);
    set_date(2, 29, 1900);
    set_date(2, 29, 2100);
    set_date(3, 0, 2000);
    set_date(2, 29, 2000);
    set_date(1, 1, 1900);
    set_date(2, 29, 2024);
  endtask

  // Month ends, the leap day and a year end
  task automatic test_month_year_rollover();
    set_date(2, 28, 2024);
    advance_by(1);
    advance_by(1);
    set_date(12, 31, 2100);
    advance_by(1);
  endtask

  // Full counts until the year saturates, then further advances stay put
  task automatic test_year_saturation();
    while (date_year != YEAR_MAX) advance_by(16'hFFFF);
    advance_by(16'hFFFF);
    advance_by(1);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    wait_for_results();
    idle_en           = 1'b0;
    receiver_hold_req = 1'b1;
    repeat (16) advance_by($urandom_range(0, 40));
    wait_for_results();
    idle_en = 1'b1;
  endtask

  // Mostly well-formed sets near month ends and short advances, with some raw noise
  task automatic test_random_mix(input int n_items);
    int          r;
    int unsigned m, d, y, len;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        y   = $urandom_range(YEAR_SET_MIN, YEAR_SET_MAX);
        m   = $urandom_range(MONTH_JAN, MONTH_DEC);
        len = days_in_month(m, y);
        d   = $urandom_range(0, 1) ? $urandom_range(len - 2, len) : $urandom_range(1, len);
        set_date(m, d, y);
      end else if (r < 48) begin
        set_date($urandom, $urandom, $urandom);
      end else if (r < 80) begin
        advance_by($urandom_range(0, 3));
      end else if (r < 97) begin
        advance_by($urandom_range(0, 400));
      end else if (r < 99) begin
        advance_by($urandom_range(0, 3000));
      end else begin
        advance_by($urandom);
      end
    end
    wait_for_results();
  endtask

  // Receiver: random hold-off per result, or the long one when asked
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = idle_en ? $urandom_range(0, 5) : 0;
      if (receiver_hold_req) begin
        wait_cycles       = LONG_HOLD;
        receiver_hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o && !out_stall_i));
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    date_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        $error("result with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_r = pending_dates.pop_front();
        check_field("cur_month", exp_r.cur_month, cur_month_o);
        check_field("cur_day", exp_r.cur_day, cur_day_o);
        check_field("cur_year", exp_r.cur_year, cur_year_o);
        check_field("old_month", exp_r.old_month, old_month_o);
        check_field("old_day", exp_r.old_day, old_day_o);
        check_field("old_year", exp_r.old_year, old_year_o);
        check_field("status", exp_r.status, status_o);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    date_day   = DAY_FIRST;
    date_month = MONTH_JAN;
    date_year  = YEAR_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_set_validation();
    test_month_year_rollover();
    test_year_saturation();
    wait_for_results();
    test_random_mix(350);
    test_backpressure();
    idle_en = 1'b0;
    test_random_mix(350);
    idle_en = 1'b1;
    test_random_mix(350);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
